[rtl/swtk_pkg.sv]
package swtk_pkg;

  // address space of the counted accesses
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned ADDR_SPACE = 4096;
  localparam logic [ADDR_W-1:0] ADDR_LAST = 12'hFFF;

  // sliding window ring
  localparam int unsigned WIN_DEPTH = 256;
  localparam int unsigned WIN_AW    = 8;
  localparam int unsigned FILL_W    = 9;

  // per-address window count, 0..WIN_DEPTH
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] CNT_SAT = 9'd256;

  // top list
  localparam int unsigned TOP_MAX = 16;
  localparam int unsigned TOP_IW  = 4;
  localparam int unsigned TOP_NW  = 5;

  // configuration register
  localparam int unsigned LIM_W = 5;
  localparam logic [LIM_W-1:0] LIM_RESET = 5'd10;
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_TOP_LIMIT = 1'b0;

  // input actions
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // controller states, one-hot
  typedef enum logic [9:0] {
    ST_CLEAR = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_REC0  = 10'b00_0000_0100,
    ST_REC1  = 10'b00_0000_1000,
    ST_REC2  = 10'b00_0001_0000,
    ST_REC3  = 10'b00_0010_0000,
    ST_REC4  = 10'b00_0100_0000,
    ST_SCAN  = 10'b00_1000_0000,
    ST_DRAIN = 10'b01_0000_0000,
    ST_EMIT  = 10'b10_0000_0000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic              clr_wr;     // write zero to count at sweep address
    logic              rec_load;   // capture recorded address
    logic              old_rd;     // read count of the leaving address
    logic              ring_wr;    // write recorded address into the ring
    logic              old_wr;     // write back decremented leaving count
    logic              new_rd;     // read count of the recorded address
    logic              new_wr;     // write back incremented count, advance ring
    logic              scan_start; // empty the top list
    logic              scan_rd;    // read count at sweep address for the scan
    logic              pop;        // result transfer, shift the top list
    logic [ADDR_W-1:0] sweep_addr;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ring_full;
    logic list_empty;
    logic list_one;
  } dp_sts_t;

endpackage

[rtl/swtk_ram.sv]
module swtk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/swtk_ctrl.sv]
module swtk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  swtk_pkg::dp_sts_t sts,
  output swtk_pkg::dp_cmd_t cmd
);

  swtk_pkg::state_t          state_r, state_nxt;
  logic [swtk_pkg::ADDR_W-1:0] sweep_r, sweep_nxt;
  logic                      in_xfer;
  logic                      out_xfer;
  logic                      sweep_end;

  assign in_stall  = (state_r != swtk_pkg::ST_IDLE);
  assign out_valid = (state_r == swtk_pkg::ST_EMIT);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign sweep_end = (sweep_r == swtk_pkg::ADDR_LAST);

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    cmd            = '0;
    cmd.sweep_addr = sweep_r;
    unique case (state_r)
      swtk_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        sweep_nxt  = sweep_r + 1'b1;
        if (sweep_end) begin
          state_nxt = swtk_pkg::ST_IDLE;
        end
      end
      swtk_pkg::ST_IDLE: begin
        sweep_nxt = '0;
        if (in_xfer) begin
          if (in_action == swtk_pkg::ACT_QUERY) begin
            cmd.scan_start = 1'b1;
            state_nxt      = swtk_pkg::ST_SCAN;
          end else begin
            cmd.rec_load = 1'b1;
            state_nxt    = swtk_pkg::ST_REC0;
          end
        end
      end
      swtk_pkg::ST_REC0: begin
        // ring read of the slot about to be overwritten is in flight
        state_nxt = swtk_pkg::ST_REC1;
      end
      swtk_pkg::ST_REC1: begin
        cmd.old_rd  = sts.ring_full;
        cmd.ring_wr = 1'b1;
        state_nxt   = swtk_pkg::ST_REC2;
      end
      swtk_pkg::ST_REC2: begin
        cmd.old_wr = sts.ring_full;
        state_nxt  = swtk_pkg::ST_REC3;
      end
      swtk_pkg::ST_REC3: begin
        cmd.new_rd = 1'b1;
        state_nxt  = swtk_pkg::ST_REC4;
      end
      swtk_pkg::ST_REC4: begin
        cmd.new_wr = 1'b1;
        state_nxt  = swtk_pkg::ST_IDLE;
      end
      swtk_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        sweep_nxt   = sweep_r + 1'b1;
        if (sweep_end) begin
          state_nxt = swtk_pkg::ST_DRAIN;
        end
      end
      swtk_pkg::ST_DRAIN: begin
        // last scanned count is merged into the list this cycle
        state_nxt = swtk_pkg::ST_EMIT;
      end
      swtk_pkg::ST_EMIT: begin
        if (out_xfer) begin
          cmd.pop = 1'b1;
          if (sts.list_empty || sts.list_one) begin
            state_nxt = swtk_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = swtk_pkg::ST_CLEAR;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swtk_pkg::ST_CLEAR;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
    end
  end

endmodule

[rtl/swtk_dp.sv]
module swtk_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [swtk_pkg::ADDR_W-1:0]   in_access_address,
  input  logic [swtk_pkg::LIM_W-1:0]    lim,
  input  swtk_pkg::dp_cmd_t             cmd,
  output swtk_pkg::dp_sts_t             sts,
  output logic [swtk_pkg::ADDR_W-1:0]   out_top_address,
  output logic [swtk_pkg::CNT_W-1:0]    out_access_count,
  output logic                          out_none_found,
  output logic                          out_last
);

  // ring state
  logic [swtk_pkg::WIN_AW-1:0] pos_r;
  logic [swtk_pkg::FILL_W-1:0] fill_r;
  logic [swtk_pkg::ADDR_W-1:0] new_addr_r;
  logic [swtk_pkg::ADDR_W-1:0] old_addr_r;
  logic [swtk_pkg::ADDR_W-1:0] ring_rdata;

  // count memory ports
  logic                        cnt_we;
  logic [swtk_pkg::ADDR_W-1:0] cnt_waddr;
  logic [swtk_pkg::CNT_W-1:0]  cnt_wdata;
  logic [swtk_pkg::ADDR_W-1:0] cnt_raddr;
  logic [swtk_pkg::CNT_W-1:0]  cnt_rdata;
  logic [swtk_pkg::CNT_W-1:0]  cnt_dec;
  logic [swtk_pkg::CNT_W-1:0]  cnt_inc;

  // scan pipeline and top list
  logic                        scan_v_r;
  logic [swtk_pkg::ADDR_W-1:0] scan_a_r;
  logic [swtk_pkg::ADDR_W-1:0] lst_addr_r [swtk_pkg::TOP_MAX];
  logic [swtk_pkg::CNT_W-1:0]  lst_cnt_r  [swtk_pkg::TOP_MAX];
  logic [swtk_pkg::TOP_NW-1:0] n_r;
  logic [swtk_pkg::TOP_MAX-1:0] ge;
  logic [swtk_pkg::TOP_IW-1:0] lim_idx;
  logic                        ins;

  swtk_ram #(
    .WIDTH(swtk_pkg::ADDR_W),
    .DEPTH(swtk_pkg::WIN_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.ring_wr),
    .waddr(pos_r),
    .wdata(new_addr_r),
    .raddr(pos_r),
    .rdata(ring_rdata)
  );

  swtk_ram #(
    .WIDTH(swtk_pkg::CNT_W),
    .DEPTH(swtk_pkg::ADDR_SPACE)
  ) u_counts (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .raddr(cnt_raddr),
    .rdata(cnt_rdata)
  );

  // count update arithmetic: no underflow, saturate at window depth
  assign cnt_dec = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - 1'b1;
  assign cnt_inc = (cnt_rdata == swtk_pkg::CNT_SAT) ? cnt_rdata : cnt_rdata + 1'b1;

  // count memory address and data selection
  always_comb begin
    if (cmd.old_rd) begin
      cnt_raddr = ring_rdata;
    end else if (cmd.new_rd) begin
      cnt_raddr = new_addr_r;
    end else begin
      cnt_raddr = cmd.sweep_addr;
    end
    cnt_we = cmd.clr_wr || cmd.old_wr || cmd.new_wr;
    if (cmd.old_wr) begin
      cnt_waddr = old_addr_r;
      cnt_wdata = cnt_dec;
    end else if (cmd.new_wr) begin
      cnt_waddr = new_addr_r;
      cnt_wdata = cnt_inc;
    end else begin
      cnt_waddr = cmd.sweep_addr;
      cnt_wdata = '0;
    end
  end

  // address capture for the record sequence
  always_ff @(posedge clk) begin
    if (cmd.rec_load) begin
      new_addr_r <= in_access_address;
    end
    if (cmd.old_rd) begin
      old_addr_r <= ring_rdata;
    end
  end

  // ring position and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else if (cmd.new_wr) begin
      pos_r <= pos_r + 1'b1;
      if (!sts.ring_full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // scan read data arrives in the cycle after the address; valid and address are registered to match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= cmd.scan_rd;
    end
    scan_a_r <= cmd.sweep_addr;
  end

  // slots that stay ahead of the scanned count
  always_comb begin
    for (int i = 0; i < swtk_pkg::TOP_MAX; i++) begin
      ge[i] = (swtk_pkg::TOP_NW'(i) < n_r) && (lst_cnt_r[i] >= cnt_rdata);
    end
  end

  assign lim_idx = swtk_pkg::TOP_IW'(lim - swtk_pkg::LIM_W'(1));
  assign ins     = scan_v_r && (cnt_rdata != '0) && !ge[lim_idx];

  // list fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (cmd.scan_start) begin
      n_r <= '0;
    end else if (ins && (n_r < swtk_pkg::TOP_NW'(lim))) begin
      n_r <= n_r + 1'b1;
    end else if (cmd.pop && (n_r != '0)) begin
      n_r <= n_r - 1'b1;
    end
  end

  // sorted insertion during the scan, shift toward the head on each transfer
  always_ff @(posedge clk) begin
    if (ins) begin
      if (!ge[0]) begin
        lst_addr_r[0] <= scan_a_r;
        lst_cnt_r[0]  <= cnt_rdata;
      end
      for (int i = 1; i < swtk_pkg::TOP_MAX; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            lst_addr_r[i] <= scan_a_r;
            lst_cnt_r[i]  <= cnt_rdata;
          end else begin
            lst_addr_r[i] <= lst_addr_r[i-1];
            lst_cnt_r[i]  <= lst_cnt_r[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < swtk_pkg::TOP_MAX - 1; i++) begin
        lst_addr_r[i] <= lst_addr_r[i+1];
        lst_cnt_r[i]  <= lst_cnt_r[i+1];
      end
    end
  end

  // status
  assign sts.ring_full  = (fill_r == swtk_pkg::FILL_W'(swtk_pkg::WIN_DEPTH));
  assign sts.list_empty = (n_r == '0);
  assign sts.list_one   = (n_r == swtk_pkg::TOP_NW'(1));

  // result fields from the list head
  assign out_top_address  = sts.list_empty ? '0 : lst_addr_r[0];
  assign out_access_count = sts.list_empty ? '0 : lst_cnt_r[0];
  assign out_none_found   = sts.list_empty;
  assign out_last         = sts.list_empty || sts.list_one;

endmodule

[rtl/sliding_window_top_k_counter_top.sv]
// Sliding-window access counter with a top-k query. Each input transfer either
// records one twelve-bit address into a 256-deep window (action 0, no result)
// or asks for the most frequent addresses of the window (action 1), which come
// out largest count first, lower address first on ties, at most top_limit of
// them (clamped to 1..16), the final one flagged last; an all-zero window
// gives a single result flagged none_found. After reset the block sweeps its
// 4096-entry count memory to zero and holds in_stall high meanwhile. A record
// reads the leaving address from the ring and then does two read-modify-writes
// (the leaving count only once the window is full) through the single read
// port and single write port of the count memory. A query scans the whole
// count memory one address per cycle, then gives out one result per transfer
// while out_stall is low. One item is in flight at a time.
module sliding_window_top_k_counter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [swtk_pkg::ADDR_W-1:0]          in_access_address,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [swtk_pkg::ADDR_W-1:0]          out_top_address,
  output logic [swtk_pkg::CNT_W-1:0]           out_access_count,
  output logic                                 out_none_found,
  output logic                                 out_last,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swtk_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [swtk_pkg::LIM_W-1:0] top_limit_r;
  logic [swtk_pkg::LIM_W-1:0] lim_eff;
  logic                       reg_sel;
  swtk_pkg::dp_cmd_t          cmd;
  swtk_pkg::dp_sts_t          sts;

  // register interface
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == swtk_pkg::REG_TOP_LIMIT);
  assign prdata  = reg_sel ? {{(32 - swtk_pkg::LIM_W){1'b0}}, top_limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_limit_r <= swtk_pkg::LIM_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      top_limit_r <= pwdata[swtk_pkg::LIM_W-1:0];
    end
  end

  // limit clamped to 1..TOP_MAX
  always_comb begin
    if (top_limit_r == '0) begin
      lim_eff = swtk_pkg::LIM_W'(1);
    end else if (top_limit_r > swtk_pkg::LIM_W'(swtk_pkg::TOP_MAX)) begin
      lim_eff = swtk_pkg::LIM_W'(swtk_pkg::TOP_MAX);
    end else begin
      lim_eff = top_limit_r;
    end
  end

  swtk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swtk_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_access_address(in_access_address),
    .lim              (lim_eff),
    .cmd              (cmd),
    .sts              (sts),
    .out_top_address  (out_top_address),
    .out_access_count (out_access_count),
    .out_none_found   (out_none_found),
    .out_last         (out_last)
  );

  // no new item is taken while results are pending
  a_no_accept_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a query result is pending");

  // the final transfer of a query ends the result stream
  a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("results continue after the last transfer");

  // a listed address always carries a nonzero count
  a_listed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_none_found) |-> (out_access_count != '0))
    else $error("top list entry with zero count");

endmodule
